[rtl/psts_pkg.sv]
// Shared types and constants for the PSK symbol timing sync block.
// Used by psts_ctrl, psts_dp and psk_symbol_timing_sync; no dependencies.
`timescale 1ns / 1ps

package psts_pkg;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_WIN = 2'd1;

	localparam logic [31:0] PHASE_INC_RESET = 32'h1000_0000;
	localparam logic [9:0] DRIFT_WIN_RESET = 10'd313;

	// energy clip: above 4.0 in Q8.24 becomes 1.0
	localparam logic [31:0] ENERGY_CLIP = 32'h0400_0000;
	localparam logic [31:0] ENERGY_ONE = 32'h0100_0000;

	// leaky average: (81*avg + e + 41) / 82, divide by reciprocal
	localparam logic [30:0] AVG_KEEP = 31'd81;
	localparam logic [30:0] AVG_ROUND = 31'd41;
	localparam logic [30:0] AVG_RECIP = 31'd1676084799;
	localparam int RECIP_SHIFT = 37;
	localparam int AVG_W = 24;

	// drift measurement
	localparam logic signed [10:0] DRIFT_CNT_MAX = 11'sb011_1111_1111;
	localparam logic signed [10:0] DRIFT_CNT_MIN = 11'sb100_0000_0000;
	localparam logic [9:0] DRIFT_TIMER_MAX = 10'h3FF;
	localparam logic signed [19:0] PPM_PER_CNT = 20'sd200;
	localparam logic signed [19:0] EST_MAX = 20'sd65535;
	localparam logic signed [19:0] EST_MIN = -20'sd65536;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_QUOT,
		ST_COMMIT,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic quot;
		logic commit;
		logic scan;
		logic finish;
		logic push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sym_end;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

[rtl/psts_ctrl.sv]
// Sequencer for the PSK symbol timing sync block.
// Depends on psts_pkg for state, command and status types.
`timescale 1ns / 1ps

module psts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  psts_pkg::sts_t sts,
	output psts_pkg::cmd_t cmd
);
	import psts_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_QUOT;
			ST_QUOT: state_d = ST_COMMIT;
			ST_COMMIT: begin
				state_d = sts.sym_end ? ST_SCAN : ST_OUT;
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_SUM: cmd.sum = 1'b1;
			ST_QUOT: cmd.quot = 1'b1;
			ST_COMMIT: cmd.commit = 1'b1;
			ST_SCAN: cmd.scan = 1'b1;
			ST_TAIL: cmd = '0;
			ST_FINISH: cmd.finish = 1'b1;
			ST_OUT: cmd.push = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/psts_dp.sv]
// Datapath: energy, leaky bin averages, peak scan, drift and output register.
// Depends on psts_pkg; driven by commands from psts_ctrl.
`timescale 1ns / 1ps

module psts_dp #(
	parameter int BINS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  psts_pkg::cmd_t                       cmd,
	output psts_pkg::sts_t                       sts,
	input  logic                                 cfg_we,
	input  logic [psts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psts_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [15:0]                   sample_i,
	input  logic signed [15:0]                   sample_q,
	input  logic                                 squelch_open,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 symbol_center,
	output logic [$clog2(BINS)-1:0]              peak_bin,
	output logic signed [16:0]                   clock_error_ppm
);
	import psts_pkg::*;

	localparam int PW = $clog2(BINS);
	localparam int BW = $clog2(BINS + 1);
	localparam logic [PW:0] HALF = (PW + 1)'(BINS / 2);
	localparam logic [PW:0] BINS_P = (PW + 1)'(BINS);
	localparam logic [PW-1:0] LAST = PW'(BINS - 1);
	localparam logic [BW-1:0] LAST_B = BW'(BINS - 1);
	localparam logic [BW-1:0] FULL_B = BW'(BINS);

	// configuration
	logic [31:0] phase_inc_q;
	logic [9:0] drift_win_q;

	// latched request
	logic signed [15:0] si_q;
	logic signed [15:0] sq_q;
	logic squelch_q;

	// arithmetic pipeline
	logic [30:0] prod_i_s1;
	logic [30:0] prod_q_s1;
	logic [30:0] num_s2;
	logic [AVG_W-1:0] avg_s3;

	// bin average memory with reset-valid bits
	logic [AVG_W-1:0] mem_q [BINS];
	logic [BINS-1:0] vld_q;
	logic [AVG_W-1:0] rdata_s1;
	logic rvld_s1;
	logic [PW-1:0] raddr;

	// timing state
	logic [BW-1:0] bin_index_q;
	logic [PW-1:0] peak_q;
	logic [PW-1:0] pending_q;
	logic [PW-1:0] prev_q;
	logic [31:0] phase_q;
	logic center_q;

	// scan
	logic [PW-1:0] scan_k_q;
	logic [PW-1:0] scan_idx_s1;
	logic scan_act_s1;
	logic [AVG_W-1:0] best_val_q;
	logic [PW-1:0] best_idx_q;

	// drift
	logic signed [10:0] cnt_q;
	logic [9:0] timer_q;
	logic signed [16:0] est_q;

	// output register
	logic out_valid_q;
	logic out_center_q;
	logic [PW-1:0] out_peak_q;
	logic signed [16:0] out_est_q;

	// combinational helpers
	logic bin_full;
	logic [PW-1:0] bin_addr;
	logic [AVG_W-1:0] avg_rd;
	logic signed [31:0] i_sqr;
	logic signed [31:0] q_sqr;
	logic [31:0] energy;
	logic [31:0] energy_c;
	logic [61:0] quot_p;
	logic [32:0] phase_sum;
	logic [PW:0] half_pos;
	logic [PW-1:0] half_bin;
	logic [BW-1:0] b_next;
	logic [PW-1:0] peak_next;
	logic center_next;
	logic signed [10:0] cnt_next;
	logic signed [19:0] est_full;
	logic signed [16:0] est_sat;
	logic drift_latch;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= PHASE_INC_RESET;
			drift_win_q <= DRIFT_WIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_INC: phase_inc_q <= cfg_data;
				REG_DRIFT_WIN: drift_win_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// latch accepted request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			si_q <= sample_i;
			sq_q <= sample_q;
			squelch_q <= squelch_open;
		end
	end

	// square both components
	assign i_sqr = 32'(si_q) * 32'(si_q);
	assign q_sqr = 32'(sq_q) * 32'(sq_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_i_s1 <= i_sqr[30:0];
			prod_q_s1 <= q_sqr[30:0];
		end
	end

	// energy, clip and weighted sum
	assign energy = {1'b0, prod_i_s1} + {1'b0, prod_q_s1};
	assign energy_c = (energy > ENERGY_CLIP) ? ENERGY_ONE : energy;
	assign avg_rd = rvld_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			num_s2 <= 31'(avg_rd) * AVG_KEEP + 31'(energy_c[26:3]) + AVG_ROUND;
		end
	end

	// divide by 82 through the reciprocal
	assign quot_p = 62'(num_s2) * 62'(AVG_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.quot) begin
			avg_s3 <= quot_p[RECIP_SHIFT +: AVG_W];
		end
	end

	// memory port: one read address, registered data
	assign bin_full = (bin_index_q >= FULL_B);
	assign bin_addr = bin_full ? '0 : bin_index_q[PW-1:0];
	assign raddr = cmd.scan ? scan_k_q : bin_addr;

	always_ff @(posedge clk) begin
		if (cmd.commit && !bin_full) begin
			mem_q[bin_addr] <= avg_s3;
		end
		rdata_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (cmd.commit && !bin_full) begin
				vld_q[bin_addr] <= 1'b1;
			end
			rvld_s1 <= vld_q[raddr];
		end
	end

	// bin counter, center flag, peak move and phase step
	assign half_pos = {1'b0, pending_q} + HALF;
	assign half_bin = (half_pos >= BINS_P) ? PW'(half_pos - BINS_P) : half_pos[PW-1:0];
	assign phase_sum = {1'b0, phase_q} + {1'b0, phase_inc_q};

	always_comb begin
		center_next = !bin_full && (bin_index_q == BW'(peak_q));
		peak_next = (!bin_full && (bin_index_q == BW'(half_bin))) ? pending_q : peak_q;
		b_next = bin_full ? bin_index_q : bin_index_q + BW'(1);
		if (phase_sum[32]) begin
			if (b_next == LAST_B && peak_next == LAST) begin
				center_next = 1'b1;
			end
			b_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_index_q <= '0;
			peak_q <= '0;
			phase_q <= '0;
		end else if (cmd.commit) begin
			bin_index_q <= b_next;
			peak_q <= peak_next;
			phase_q <= phase_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			center_q <= center_next;
		end
	end

	// argmax sweep, lowest bin wins a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_k_q <= '0;
			scan_act_s1 <= 1'b0;
		end else begin
			scan_act_s1 <= cmd.scan;
			if (cmd.commit) begin
				scan_k_q <= '0;
			end else if (cmd.scan) begin
				scan_k_q <= scan_k_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_k_q;
		if (scan_act_s1) begin
			if (scan_idx_s1 == '0 || avg_rd > best_val_q) begin
				best_val_q <= avg_rd;
				best_idx_q <= scan_idx_s1;
			end
		end
	end

	// drift count and estimate
	always_comb begin
		cnt_next = cnt_q;
		if ({1'b0, peak_q} == {1'b0, prev_q} + (PW + 1)'(1)) begin
			if (cnt_q != DRIFT_CNT_MAX) begin
				cnt_next = cnt_q + 11'sd1;
			end
		end else if (prev_q != '0 && peak_q == prev_q - PW'(1)) begin
			if (cnt_q != DRIFT_CNT_MIN) begin
				cnt_next = cnt_q - 11'sd1;
			end
		end
		est_full = 20'(cnt_next) * PPM_PER_CNT;
		if (est_full > EST_MAX) begin
			est_sat = 17'(EST_MAX);
		end else if (est_full < EST_MIN) begin
			est_sat = 17'(EST_MIN);
		end else begin
			est_sat = est_full[16:0];
		end
		drift_latch = (timer_q > drift_win_q) || (timer_q == DRIFT_TIMER_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PW'(5 % BINS);
			prev_q <= '0;
			cnt_q <= '0;
			timer_q <= '0;
			est_q <= '0;
		end else if (cmd.finish) begin
			pending_q <= best_idx_q;
			prev_q <= peak_q;
			if (!squelch_q) begin
				cnt_q <= '0;
				timer_q <= '0;
				est_q <= '0;
			end else if (drift_latch) begin
				cnt_q <= '0;
				timer_q <= '0;
				est_q <= est_sat;
			end else begin
				cnt_q <= cnt_next;
				timer_q <= timer_q + 10'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_center_q <= center_q;
			out_peak_q <= peak_q;
			out_est_q <= est_q;
		end
	end

	assign sts.sym_end = phase_sum[32];
	assign sts.scan_last = (scan_k_q == LAST);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign symbol_center = out_center_q;
	assign peak_bin = out_peak_q;
	assign clock_error_ppm = out_est_q;

	// never overwrite a result that is still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || !out_stall))
		else $error("result pushed over a stalled result");

	// bin counter stays within 0..BINS
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		bin_index_q <= FULL_B)
		else $error("bin index out of range");

	// a symbol end restarts the bin counter
	a_sym_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && phase_sum[32]) |=> (bin_index_q == '0))
		else $error("bin counter not restarted at symbol end");

	// chosen peaks are real bins
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_q <= LAST) && (pending_q <= LAST))
		else $error("peak outside bin range");

endmodule

[rtl/psk_symbol_timing_sync.sv]
// Top level of the PSK symbol timing sync block: controller plus datapath.
// Depends on psts_pkg, psts_ctrl and psts_dp.
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// input     in         in_valid / in_stall   sample_i, sample_q, squelch_open
// output    out        out_valid / out_stall symbol_center, peak_bin, clock_error_ppm
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An ordinary sample passes from accept to the next accept through square,
// weighted sum, reciprocal multiply, commit and output load in turn.
// A symbol end adds the argmax sweep over the single memory read port
// and the drift update before the output load.
// Reset is asynchronous and clears all bin averages at once through valid bits.
// A result waits in the output register under out_stall while the next
// sample is taken; in_stall stays high from accept until the result is
// loaded, and longer while the output register still holds a stalled result.

module psk_symbol_timing_sync #(
	parameter int BINS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [15:0]                   sample_i,
	input  logic signed [15:0]                   sample_q,
	input  logic                                 squelch_open,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 symbol_center,
	output logic [$clog2(BINS)-1:0]              peak_bin,
	output logic signed [16:0]                   clock_error_ppm,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [psts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psts_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import psts_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	// registers are always writable
	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	psts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	psts_dp #(
		.BINS (BINS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_i        (sample_i),
		.sample_q        (sample_q),
		.squelch_open    (squelch_open),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.symbol_center   (symbol_center),
		.peak_bin        (peak_bin),
		.clock_error_ppm (clock_error_ppm)
	);

endmodule
